>>> rtl/core/barometric_sensor_compensation_assert.svh
// Assertion macros shared by the compensation block.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`ifndef ASSERT_OFF
`define BSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
`define BSC_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BSC_ASSERT(lbl, prop)
`define BSC_ASSERT_RST(lbl, prop)
`endif
`endif

>>> rtl/core/bsc_pkg.sv
// Types, constants and helpers of the barometric compensation block.
package bsc_pkg;
	localparam int QDEPTH = 4;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PA = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PB = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PC = 8'd3;

	localparam logic [63:0] T_OFFSET = 64'd128000;
	localparam logic [63:0] P_BASE = 64'd1048576;
	localparam logic [63:0] P_SCALE = 64'd3125;
	localparam logic [63:0] P_BIAS = 64'h0000_8000_0000_0000;
	localparam logic [31:0] C_ROUND = 32'd128;

	typedef struct packed {
		logic [19:0] adc_pressure;
		logic [19:0] adc_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic signed [31:0] fine_temperature;
		logic [31:0] pressure_q24_8;
		logic pressure_invalid;
	} result_t;

	typedef struct packed {
		logic [31:0] centi;
		logic [31:0] tfine;
		logic [19:0] adc_p;
	} qword_t;

	typedef struct packed {
		logic [15:0] t1, t2, t3;
		logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	} cal_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_POST, ST_DIV, ST_DSIGN, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_SQ, OP_V2A, OP_V2B, OP_V1A, OP_V1B, OP_V1C, OP_NUM, OP_W1A, OP_W1B, OP_W2
	} op_t;

	function automatic logic [63:0] sx64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction
endpackage

>>> rtl/core/barometric_sensor_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
// Raw temperature and pressure words enter a three-stage temperature pipeline that
// takes one word per cycle unless a full queue stalls it, and feeds a short queue.
// A pressure engine drains the queue one word at a time: ten 64-bit products on one
// shared 32x32 multiplier and a 64-step radix-2 signed divider; when the pressure
// divisor is zero, the divider and the remaining products are skipped. A finished
// result waits in the output register while the result is stalled, and this engine
// sets the sustained rate. Calibration registers are written through the cfg port,
// which is always ready, and reset to zero.
module barometric_sensor_compensation import bsc_pkg::*; #(
	parameter int QUEUE_DEPTH = QDEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input sample_t sample,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [63:0] cfg_data
);
	logic [47:0] cal_temp_q;
	logic [63:0] cal_pa_q, cal_pb_q;
	logic [15:0] cal_pc_q;
	cal_t cal;
	logic q_full, q_push, q_pop, q_valid;
	qword_t q_in, q_out;

	assign cfg_ready = 1'b1;
	assign cal = '{t1: cal_temp_q[15:0], t2: cal_temp_q[31:16], t3: cal_temp_q[47:32],
		p1: cal_pa_q[15:0], p2: cal_pa_q[31:16], p3: cal_pa_q[47:32], p4: cal_pa_q[63:48],
		p5: cal_pb_q[15:0], p6: cal_pb_q[31:16], p7: cal_pb_q[47:32], p8: cal_pb_q[63:48],
		p9: cal_pc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q <= '0;
			cal_pa_q <= '0;
			cal_pb_q <= '0;
			cal_pc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CAL_TEMP: cal_temp_q <= cfg_data[47:0];
				REG_CAL_PA: cal_pa_q <= cfg_data;
				REG_CAL_PB: cal_pb_q <= cfg_data;
				REG_CAL_PC: cal_pc_q <= cfg_data[15:0];
				default: cal_pc_q <= cal_pc_q;
			endcase
		end
	end

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.cal(cal), .q_full(q_full), .q_push(q_push), .q_word(q_in)
	);

	bsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_in), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .rdata(q_out)
	);

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_word(q_out), .cal(cal),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);
endmodule

>>> rtl/core/bsc_front.sv
// Front end: accepts raw samples and runs the temperature compensation pipeline.
module bsc_front import bsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input sample_t sample,
	input cal_t cal,
	input logic q_full,
	output logic q_push,
	output qword_t q_word
);
	logic en;
	logic v_s1, v_s2, v_s3;
	logic [31:0] m1_s1, m2_s1, tv1_s2, m3_s2, tfine_s3, centi_s3;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3;
	logic [31:0] adct, d1, d2, tfine, t5;

	assign en = !(v_s3 && q_full);
	assign sample_stall = !en;
	assign q_push = v_s3 && !q_full;
	assign q_word = '{centi: centi_s3, tfine: tfine_s3, adc_p: adcp_s3};

	assign adct = {12'b0, sample.adc_temperature};
	assign d1 = (adct >> 3) - {15'b0, cal.t1, 1'b0};
	assign d2 = (adct >> 4) - {16'b0, cal.t1};
	assign tfine = tv1_s2 + 32'($signed(m3_s2) >>> 14);
	assign t5 = (tfine << 2) + tfine + C_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= d1 * sx32(cal.t2);
			m2_s1 <= d2 * d2;
			adcp_s1 <= sample.adc_pressure;
			tv1_s2 <= 32'($signed(m1_s1) >>> 11);
			m3_s2 <= 32'($signed(m2_s1) >>> 12) * sx32(cal.t3);
			adcp_s2 <= adcp_s1;
			tfine_s3 <= tfine;
			centi_s3 <= 32'($signed(t5) >>> 8);
			adcp_s3 <= adcp_s2;
		end
	end
endmodule

>>> rtl/core/bsc_queue.sv
// Short word queue between the front end and the pressure engine.
module bsc_queue import bsc_pkg::*; #(
	parameter int DEPTH = QDEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input qword_t wdata,
	output logic full,
	input logic pop,
	output logic not_empty,
	output qword_t rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qword_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end
endmodule

>>> rtl/core/bsc_back.sv
// Pressure engine: shared multiplier and radix-2 divider driven by a sequencer.
`include "barometric_sensor_compensation_assert.svh"
module bsc_back import bsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input qword_t q_word,
	input cal_t cal,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);
	state_t state_q, state_d;
	op_t op_q, op_d;
	logic [1:0] ph_q;
	logic [5:0] cnt_q;
	logic res_valid_q, res_load;

	logic [63:0] mx_q, my_q, prod_q, v1_q, sq_q, v2_q, a_q, p_q, w_q, rem_q, quo_q, div_q;
	logic [31:0] cross_q, centi_q, tfine_q, pres_q;
	logic [19:0] adcp_q;
	logic sgn_q, inv_q;
	result_t res_q;

	logic [31:0] ma, mb;
	logic [63:0] mp, asr8, asr19, asr25, asr33, tf64, v1_new, num0, pval, sum3;
	logic [64:0] rem_sh;
	logic d_zero, ge;

	assign ma = (ph_q == 2'd2) ? mx_q[63:32] : mx_q[31:0];
	assign mb = (ph_q == 2'd1) ? my_q[63:32] : my_q[31:0];
	assign mp = ma * mb;

	assign asr8 = 64'($signed(prod_q) >>> 8);
	assign asr19 = 64'($signed(prod_q) >>> 19);
	assign asr25 = 64'($signed(prod_q) >>> 25);
	assign asr33 = 64'($signed(prod_q) >>> 33);
	assign d_zero = (asr33 == '0);
	assign tf64 = {{32{q_word.tfine[31]}}, q_word.tfine};
	assign v1_new = tf64 - T_OFFSET;
	assign num0 = ((P_BASE - {44'b0, adcp_q}) << 31) - v2_q;
	assign rem_sh = {rem_q, quo_q[63]};
	assign ge = (rem_sh >= {1'b0, div_q});
	assign pval = sgn_q ? (64'd0 - quo_q) : quo_q;
	assign sum3 = 64'($signed(p_q + w_q + asr19) >>> 8) + (sx64(cal.p7) << 4);

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign res_load = (state_q == ST_OUT) && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_MUL;
					op_d = OP_SQ;
				end
			end
			ST_MUL: begin
				if (ph_q == 2'd2) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				state_d = ST_MUL;
				unique case (op_q)
					OP_SQ: op_d = OP_V2A;
					OP_V2A: op_d = OP_V2B;
					OP_V2B: op_d = OP_V1A;
					OP_V1A: op_d = OP_V1B;
					OP_V1B: op_d = OP_V1C;
					OP_V1C: begin
						op_d = OP_NUM;
						if (d_zero) begin
							state_d = ST_OUT;
						end
					end
					OP_NUM: state_d = ST_DIV;
					OP_W1A: op_d = OP_W1B;
					OP_W1B: op_d = OP_W2;
					OP_W2: state_d = ST_OUT;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIV: begin
				if (cnt_q == 6'd63) begin
					state_d = ST_DSIGN;
				end
			end
			ST_DSIGN: begin
				state_d = ST_MUL;
				op_d = OP_W1A;
			end
			ST_OUT: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_SQ;
			ph_q <= '0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			ph_q <= (state_q == ST_MUL && ph_q != 2'd2) ? ph_q + 2'd1 : 2'd0;
			cnt_q <= (state_q == ST_DIV) ? cnt_q + 6'd1 : 6'd0;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= '{temperature_centi: centi_q, fine_temperature: tfine_q,
				pressure_q24_8: pres_q, pressure_invalid: inv_q};
		end
		unique case (state_q)
			ST_IDLE: begin
				v1_q <= v1_new;
				mx_q <= v1_new;
				my_q <= v1_new;
				centi_q <= q_word.centi;
				tfine_q <= q_word.tfine;
				adcp_q <= q_word.adc_p;
			end
			ST_MUL: begin
				unique case (ph_q)
					2'd0: prod_q <= mp;
					2'd1: cross_q <= mp[31:0];
					default: prod_q <= prod_q + {cross_q + mp[31:0], 32'b0};
				endcase
			end
			ST_POST: begin
				unique case (op_q)
					OP_SQ: begin
						sq_q <= prod_q;
						mx_q <= prod_q;
						my_q <= sx64(cal.p6);
					end
					OP_V2A: begin
						v2_q <= prod_q;
						mx_q <= v1_q;
						my_q <= sx64(cal.p5);
					end
					OP_V2B: begin
						v2_q <= v2_q + (prod_q << 17) + (sx64(cal.p4) << 35);
						mx_q <= sq_q;
						my_q <= sx64(cal.p3);
					end
					OP_V1A: begin
						a_q <= asr8;
						mx_q <= v1_q;
						my_q <= sx64(cal.p2);
					end
					OP_V1B: begin
						mx_q <= a_q + (prod_q << 12) + P_BIAS;
						my_q <= {48'b0, cal.p1};
					end
					OP_V1C: begin
						a_q <= asr33;
						inv_q <= d_zero;
						pres_q <= '0;
						mx_q <= num0;
						my_q <= P_SCALE;
					end
					OP_NUM: begin
						rem_q <= '0;
						quo_q <= prod_q[63] ? (64'd0 - prod_q) : prod_q;
						div_q <= a_q[63] ? (64'd0 - a_q) : a_q;
						sgn_q <= prod_q[63] ^ a_q[63];
					end
					OP_W1A: begin
						mx_q <= prod_q;
					end
					OP_W1B: begin
						w_q <= asr25;
						mx_q <= sx64(cal.p8);
						my_q <= p_q;
					end
					OP_W2: begin
						pres_q <= sum3[31:0];
					end
					default: begin
						pres_q <= pres_q;
					end
				endcase
			end
			ST_DIV: begin
				rem_q <= ge ? 64'(rem_sh - {1'b0, div_q}) : rem_sh[63:0];
				quo_q <= {quo_q[62:0], ge};
			end
			ST_DSIGN: begin
				p_q <= pval;
				mx_q <= sx64(cal.p9);
				my_q <= 64'($signed(pval) >>> 13);
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	`BSC_ASSERT(a_pop_idle, q_pop |-> (state_q == ST_IDLE))
	`BSC_ASSERT(a_div_exit, (state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_DSIGN))
	`BSC_ASSERT(a_inv_zero, (result_valid && result.pressure_invalid) |-> (result.pressure_q24_8 == '0))
	`BSC_ASSERT_RST(a_rst_idle, !arst_n |=> !result_valid)
endmodule

>>> tb/tb_barometric_sensor_compensation.sv
// Self-checking testbench of the barometric temperature and pressure compensation block.
`timescale 1ns / 1ps

module tb_barometric_sensor_compensation;
	import bsc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_WORDS = 500;

	typedef enum int {CAL_TYPICAL, CAL_RANDOM, CAL_ONES, CAL_MIN, CAL_MAX, CAL_NO_P1} cal_kind_t;

	typedef struct {
		bit set_cal;
		cal_kind_t kind;
		sample_t s;
		bit typed;
		result_t exp;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic sample_valid = 0;
	logic sample_stall;
	sample_t sample = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic [47:0] cal_temp_q = '0;
	logic [63:0] cal_pa_q = '0;
	logic [63:0] cal_pb_q = '0;
	logic [15:0] cal_pc_q = '0;

	result_t expected_q[$];
	bit typed_pending = 0;
	result_t typed_word;
	bit tx_idle = 0;
	bit rx_idle = 0;
	int idle_pct = 74;
	int errors = 0;
	int cycles = 0;
	row_t rows[$];

	barometric_sensor_compensation dut (.*);

	always #5 clk = ~clk;

	function automatic result_t compensate(input sample_t s);
		logic signed [31:0] t1, t2, t3, d1, d2, m, tv1, tv2, tf;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] v1, v2, pp, num, q, w1, w2;
		logic [63:0] nm, dm, uq;
		result_t r;
		t1 = {16'd0, cal_temp_q[15:0]};
		t2 = $signed(cal_temp_q[31:16]);
		t3 = $signed(cal_temp_q[47:32]);
		d1 = {15'd0, s.adc_temperature[19:3]} - (t1 <<< 1);
		m = d1 * t2;
		tv1 = m >>> 11;
		d2 = {16'd0, s.adc_temperature[19:4]} - t1;
		m = d2 * d2;
		m = m >>> 12;
		m = m * t3;
		tv2 = m >>> 14;
		tf = tv1 + tv2;
		m = tf * 32'sd5 + 32'sd128;
		r.temperature_centi = m >>> 8;
		r.fine_temperature = tf;
		p1 = {48'd0, cal_pa_q[15:0]};
		p2 = $signed(cal_pa_q[31:16]);
		p3 = $signed(cal_pa_q[47:32]);
		p4 = $signed(cal_pa_q[63:48]);
		p5 = $signed(cal_pb_q[15:0]);
		p6 = $signed(cal_pb_q[31:16]);
		p7 = $signed(cal_pb_q[47:32]);
		p8 = $signed(cal_pb_q[63:48]);
		p9 = $signed(cal_pc_q);
		v1 = {{32{tf[31]}}, tf};
		v1 = v1 - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = ((64'sh0000_8000_0000_0000 + v1) * p1) >>> 33;
		if (v1 == 0) begin
			r.pressure_q24_8 = '0;
			r.pressure_invalid = 1'b1;
		end else begin
			pp = {44'd0, s.adc_pressure};
			pp = 64'sd1048576 - pp;
			num = ((pp <<< 31) - v2) * 64'sd3125;
			nm = num[63] ? -num : num;
			dm = v1[63] ? -v1 : v1;
			uq = nm / dm;
			pp = (num[63] ^ v1[63]) ? -uq : uq;
			q = pp >>> 13;
			w1 = (p9 * q * q) >>> 25;
			w2 = (p8 * pp) >>> 19;
			pp = ((pp + w1 + w2) >>> 8) + (p7 <<< 4);
			r.pressure_q24_8 = pp[31:0];
			r.pressure_invalid = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall)
			expected_q.push_back(typed_pending ? typed_word : compensate(sample));
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result.temperature_centi !== e.temperature_centi) begin
					$error("temperature_centi expected %0d actual %0d",
						e.temperature_centi, result.temperature_centi);
					errors++;
				end
				if (result.fine_temperature !== e.fine_temperature) begin
					$error("fine_temperature expected %0d actual %0d",
						e.fine_temperature, result.fine_temperature);
					errors++;
				end
				if (result.pressure_q24_8 !== e.pressure_q24_8) begin
					$error("pressure_q24_8 expected %0h actual %0h",
						e.pressure_q24_8, result.pressure_q24_8);
					errors++;
				end
				if (result.pressure_invalid !== e.pressure_invalid) begin
					$error("pressure_invalid expected %0b actual %0b",
						e.pressure_invalid, result.pressure_invalid);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		result_stall <= rx_idle && ($urandom_range(99) < idle_pct);
	end

	task automatic drain();
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CAL_TEMP: cal_temp_q = d[47:0];
			REG_CAL_PA: cal_pa_q = d;
			REG_CAL_PB: cal_pb_q = d;
			REG_CAL_PC: cal_pc_q = d[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_cal(input cal_kind_t kind);
		logic [63:0] ct, pa, pb, pc;
		ct = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
		pa = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
		pb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
		pc = 64'd6000;
		case (kind)
			CAL_RANDOM: begin
				ct = {$urandom, $urandom};
				pa = {$urandom, $urandom};
				pb = {$urandom, $urandom};
				pc = {$urandom, $urandom};
			end
			CAL_ONES: begin
				ct = '1;
				pa = '1;
				pb = '1;
				pc = '1;
			end
			CAL_MIN: begin
				ct = {4{16'h8000}};
				pa = {4{16'h8000}};
				pb = {4{16'h8000}};
				pc = {4{16'h8000}};
			end
			CAL_MAX: begin
				ct = {4{16'h7FFF}};
				pa = {4{16'h7FFF}};
				pb = {4{16'h7FFF}};
				pc = {4{16'h7FFF}};
			end
			CAL_NO_P1: pa[15:0] = '0;
			default: ;
		endcase
		drain();
		cfg_write(REG_CAL_TEMP, ct);
		cfg_write(REG_CAL_PA, pa);
		cfg_write(REG_CAL_PB, pb);
		cfg_write(REG_CAL_PC, pc);
		cfg_write(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
	endtask

	task automatic send(input sample_t s);
		if (tx_idle) begin
			while ($urandom_range(99) < idle_pct) begin
				sample_valid <= 1'b0;
				@(negedge clk);
			end
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		@(negedge clk);
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		if ($urandom_range(99) < 80) begin
			s.adc_temperature = 20'(519888 + $urandom_range(120000) - 60000);
			s.adc_pressure = 20'(415148 + $urandom_range(200000) - 100000);
		end else begin
			s.adc_temperature = 20'($urandom);
			s.adc_pressure = 20'($urandom);
		end
		return s;
	endfunction

	function automatic row_t mk(input bit c, input cal_kind_t k, input logic [19:0] p,
		input logic [19:0] t, input bit typed);
		row_t r;
		r.set_cal = c;
		r.kind = k;
		r.s.adc_pressure = p;
		r.s.adc_temperature = t;
		r.typed = typed;
		r.exp = '{temperature_centi: 0, fine_temperature: 0, pressure_q24_8: 0,
			pressure_invalid: 1'b1};
		return r;
	endfunction

	initial begin
		rows.push_back(mk(0, CAL_TYPICAL, 20'h00000, 20'h00000, 1));
		rows.push_back(mk(0, CAL_TYPICAL, 20'hFFFFF, 20'hFFFFF, 1));
		rows.push_back(mk(0, CAL_TYPICAL, 20'h00000, 20'hFFFFF, 1));
		rows.push_back(mk(0, CAL_TYPICAL, 20'hFFFFF, 20'h00000, 1));
		rows.push_back(mk(0, CAL_TYPICAL, 20'hAAAAA, 20'h55555, 1));
		rows.push_back(mk(1, CAL_TYPICAL, 0, 0, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'd415148, 20'd519888, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'h00000, 20'h00000, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'hFFFFF, 20'hFFFFF, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'h55555, 20'hAAAAA, 0));
		rows.push_back(mk(1, CAL_NO_P1, 0, 0, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'd415148, 20'd519888, 0));
		rows.push_back(mk(1, CAL_ONES, 0, 0, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'h00000, 20'hFFFFF, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'hFFFFF, 20'h00000, 0));
		rows.push_back(mk(1, CAL_MIN, 0, 0, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'h00000, 20'h00000, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'hFFFFF, 20'hFFFFF, 0));
		rows.push_back(mk(1, CAL_MAX, 0, 0, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'h00000, 20'hFFFFF, 0));
		rows.push_back(mk(0, CAL_TYPICAL, 20'hFFFFF, 20'h00000, 0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].set_cal) begin
				sample_valid <= 1'b0;
				load_cal(rows[i].kind);
			end else begin
				typed_pending = rows[i].typed;
				typed_word = rows[i].exp;
				send(rows[i].s);
			end
		end
		sample_valid <= 1'b0;
		typed_pending = 0;

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle = (ph == 1) || (ph == 3);
			rx_idle = (ph == 2) || (ph == 3);
			idle_pct = (ph == 3) ? 8 : 74;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 100 == 0) begin
					sample_valid <= 1'b0;
					load_cal(cal_kind_t'($urandom_range(5)));
				end
				if (ph == 2 && n == 250) begin
					sample_valid <= 1'b0;
					while (expected_q.size() != 0)
						@(negedge clk);
				end
				send(random_sample());
			end
		end
		sample_valid <= 1'b0;
		rx_idle = 0;

		drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
